@@ hw/rtl/lst_pkg.sv @@
`default_nettype none
package lst_pkg;

	// Default table depth and fixed field widths.
	localparam int MaxThreadsDef = 16;
	localparam int IdW  = 8;
	localparam int TkW  = 16;
	localparam int TotW = 20;
	localparam int CntW = 5;
	localparam int RndW = 31;
	localparam int RemW = TotW + 1;
	localparam int McW  = $clog2(RndW);

	typedef enum logic [1:0] {
		ACT_ADD,
		ACT_REMOVE,
		ACT_DRAW,
		ACT_YIELD
	} act_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_IGNORED,
		ST_EMPTY,
		ST_FULL
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_MOD,
		S_SCAN,
		S_APPLY,
		S_INSERT,
		S_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    latch;
		logic    mod_start;
		logic    mod_step;
		logic    scan_load;
		logic    scan_step;
		logic    mark_hit;
		logic    drop;
		logic    insert;
		logic    set_st;
		status_t st;
		logic    out_load;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		act_t act;
		logic run;
		logic tbl_empty;
		logic mod_last;
		logic scan_end;
		logic scan_hit;
		logic hit;
		logic ins_fail;
		logic out_free;
	} flag_t;

endpackage
`default_nettype wire

@@ hw/rtl/lst_if.sv @@
`default_nettype none
// Request channel: one word is one table operation.
interface lst_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [7:0]  thread_id;
	logic [15:0] ticket_count;
	logic        thread_running;
	logic [30:0] random_value;

	modport source (output valid, action, thread_id, ticket_count, thread_running,
		random_value, input ready);
	modport sink (input valid, action, thread_id, ticket_count, thread_running,
		random_value, output ready);
	modport mon (input valid, ready, action, thread_id, ticket_count, thread_running,
		random_value);
endinterface

// Response channel: one word per request.
interface lst_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [7:0]  winner_id;
	logic [15:0] winner_tickets;
	logic [19:0] ticket_total;
	logic [4:0]  entry_count;

	modport source (output valid, status, winner_id, winner_tickets, ticket_total,
		entry_count, input ready);
	modport sink (input valid, status, winner_id, winner_tickets, ticket_total,
		entry_count, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/lst_dp.sv @@
`default_nettype none
module lst_dp #(
	parameter int MAX_THREADS = lst_pkg::MaxThreadsDef
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	lst_req_if.sink            req,
	lst_rsp_if.source          rsp,
	input  wire lst_pkg::cmd_t cmd,
	output      lst_pkg::flag_t flg
);
	import lst_pkg::*;

	localparam int CW = $clog2(MAX_THREADS + 1);

	logic [IdW-1:0]  slot_id_q [MAX_THREADS];
	logic [TkW-1:0]  slot_tk_q [MAX_THREADS];
	logic [IdW-1:0]  scan_id_q [MAX_THREADS];
	logic [TkW-1:0]  scan_tk_q [MAX_THREADS];
	logic [CW-1:0]   count_q, idx_q, hit_idx_q;
	logic [TotW-1:0] total_q;
	act_t            act_q;
	logic [IdW-1:0]  id_q, hit_id_q;
	logic [TkW-1:0]  tk_q, hit_tk_q;
	logic            run_q, hit_q, out_vld_q;
	logic [RndW-1:0] rnd_q;
	logic [RemW-1:0] rem_q, acc_q;
	logic [McW-1:0]  mcnt_q;
	status_t         st_q;

	logic [1:0]      out_st_q;
	logic [IdW-1:0]  out_id_q;
	logic [TkW-1:0]  out_tk_q;
	logic [TotW-1:0] out_tot_q;
	logic [CntW-1:0] out_cnt_q;

	logic [RemW-1:0]    mod_try, acc_nx, r_val, base, ins_sum;
	logic               mod_ge, win;
	logic [CW+CntW-1:0] cnt_ext;

	// Arithmetic for the modulo step, the walk and the insert check.
	always_comb begin
		mod_try = {rem_q[RemW-2:0], rnd_q[RndW-1]};
		mod_ge  = mod_try >= {1'b0, total_q};
		acc_nx  = acc_q + RemW'(scan_tk_q[0]);
		r_val   = rem_q + RemW'(1);
		base    = {1'b0, total_q} - (hit_q ? RemW'(hit_tk_q) : RemW'(0));
		ins_sum = base + RemW'(tk_q);
		cnt_ext = (CW+CntW)'(count_q);
		win     = (st_q == ST_OK) && (act_q == ACT_DRAW);
	end

	// Status toward the controller.
	always_comb begin
		flg.act       = act_q;
		flg.run       = run_q;
		flg.tbl_empty = (count_q == '0) || (total_q == '0);
		flg.mod_last  = (mcnt_q == '0);
		flg.scan_end  = (idx_q == count_q);
		flg.scan_hit  = (act_q == ACT_DRAW) ? (acc_nx >= r_val) : (scan_id_q[0] == id_q);
		flg.hit       = hit_q;
		flg.ins_fail  = (!hit_q && (count_q == CW'(MAX_THREADS))) || ins_sum[TotW];
		flg.out_free  = !out_vld_q || rsp.ready;
	end

	// Control state: occupancy, total, hit flag and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			total_q   <= '0;
			hit_q     <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (cmd.drop) begin
				count_q <= count_q - CW'(1);
				total_q <= total_q - TotW'(hit_tk_q);
			end else if (cmd.insert) begin
				count_q <= count_q + CW'(1);
				total_q <= total_q + TotW'(tk_q);
			end
			if (cmd.latch) begin
				hit_q <= 1'b0;
			end else if (cmd.mark_hit) begin
				hit_q <= 1'b1;
			end
			if (cmd.out_load) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Table: close a gap at the hit slot, or push a new entry in at the front.
	always_ff @(posedge clk) begin
		if (cmd.drop) begin
			for (int k = 0; k < MAX_THREADS - 1; k++) begin
				if (k >= int'(hit_idx_q)) begin
					slot_id_q[k] <= slot_id_q[k+1];
					slot_tk_q[k] <= slot_tk_q[k+1];
				end
			end
		end else if (cmd.insert) begin
			slot_id_q[0] <= id_q;
			slot_tk_q[0] <= tk_q;
			for (int k = 1; k < MAX_THREADS; k++) begin
				slot_id_q[k] <= slot_id_q[k-1];
				slot_tk_q[k] <= slot_tk_q[k-1];
			end
		end
	end

	// Walk copy of the table; the head entry is examined each cycle.
	always_ff @(posedge clk) begin
		if (cmd.scan_load) begin
			scan_id_q <= slot_id_q;
			scan_tk_q <= slot_tk_q;
			idx_q     <= '0;
			acc_q     <= '0;
		end else if (cmd.scan_step) begin
			for (int k = 0; k < MAX_THREADS - 1; k++) begin
				scan_id_q[k] <= scan_id_q[k+1];
				scan_tk_q[k] <= scan_tk_q[k+1];
			end
			idx_q <= idx_q + CW'(1);
			acc_q <= acc_nx;
		end
		if (cmd.mark_hit) begin
			hit_idx_q <= idx_q;
			hit_id_q  <= scan_id_q[0];
			hit_tk_q  <= scan_tk_q[0];
		end
	end

	// Request capture and the bit-serial modulo of the random word by the total.
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			act_q <= act_t'(req.action);
			id_q  <= req.thread_id;
			tk_q  <= req.ticket_count;
			run_q <= req.thread_running;
			rnd_q <= req.random_value;
		end else if (cmd.mod_step) begin
			rnd_q <= {rnd_q[RndW-2:0], 1'b0};
		end
		if (cmd.mod_start) begin
			rem_q  <= '0;
			mcnt_q <= McW'(RndW - 1);
		end else if (cmd.mod_step) begin
			rem_q  <= mod_ge ? (mod_try - {1'b0, total_q}) : mod_try;
			mcnt_q <= mcnt_q - McW'(1);
		end
		if (cmd.set_st) begin
			st_q <= cmd.st;
		end
	end

	// Response register.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_st_q  <= st_q;
			out_id_q  <= win ? hit_id_q : '0;
			out_tk_q  <= win ? hit_tk_q : '0;
			out_tot_q <= total_q;
			out_cnt_q <= cnt_ext[CntW-1:0];
		end
	end

	assign rsp.valid          = out_vld_q;
	assign rsp.status         = out_st_q;
	assign rsp.winner_id      = out_id_q;
	assign rsp.winner_tickets = out_tk_q;
	assign rsp.ticket_total   = out_tot_q;
	assign rsp.entry_count    = out_cnt_q;

endmodule
`default_nettype wire

@@ hw/rtl/lst_ctrl.sv @@
`default_nettype none
module lst_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output      logic           req_ready,
	input  wire lst_pkg::flag_t flg,
	output      lst_pkg::cmd_t  cmd
);
	import lst_pkg::*;

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Next state.
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) state_nx = S_DECIDE;
			end
			S_DECIDE: begin
				if (flg.act == ACT_YIELD && !flg.run) state_nx = S_DONE;
				else if (flg.act == ACT_DRAW) state_nx = flg.tbl_empty ? S_DONE : S_MOD;
				else state_nx = S_SCAN;
			end
			S_MOD: begin
				if (flg.mod_last) state_nx = S_SCAN;
			end
			S_SCAN: begin
				if (flg.scan_end || flg.scan_hit) state_nx = S_APPLY;
			end
			S_APPLY: begin
				if ((flg.act == ACT_ADD || flg.act == ACT_YIELD) && !flg.ins_fail) begin
					state_nx = S_INSERT;
				end else begin
					state_nx = S_DONE;
				end
			end
			S_INSERT: state_nx = S_DONE;
			S_DONE: begin
				if (flg.out_free) state_nx = S_IDLE;
			end
			default: state_nx = S_IDLE;
		endcase
	end

	// Commands.
	always_comb begin
		cmd       = '0;
		cmd.st    = ST_OK;
		req_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				cmd.latch = req_valid;
			end
			S_DECIDE: begin
				if (flg.act == ACT_YIELD && !flg.run) begin
					cmd.set_st = 1'b1;
					cmd.st     = ST_IGNORED;
				end else if (flg.act == ACT_DRAW) begin
					if (flg.tbl_empty) begin
						cmd.set_st = 1'b1;
						cmd.st     = ST_EMPTY;
					end else begin
						cmd.mod_start = 1'b1;
					end
				end else begin
					cmd.scan_load = 1'b1;
				end
			end
			S_MOD: begin
				cmd.mod_step  = 1'b1;
				cmd.scan_load = flg.mod_last;
			end
			S_SCAN: begin
				if (!flg.scan_end) begin
					if (flg.scan_hit) cmd.mark_hit = 1'b1;
					else cmd.scan_step = 1'b1;
				end
			end
			S_APPLY: begin
				cmd.set_st = 1'b1;
				unique case (flg.act)
					ACT_REMOVE: begin
						cmd.drop = flg.hit;
						cmd.st   = flg.hit ? ST_OK : ST_IGNORED;
					end
					ACT_DRAW: begin
						cmd.drop = flg.hit;
						cmd.st   = flg.hit ? ST_OK : ST_EMPTY;
					end
					default: begin
						cmd.drop = flg.hit && !flg.ins_fail;
						cmd.st   = flg.ins_fail ? ST_FULL : ST_OK;
					end
				endcase
			end
			S_INSERT: cmd.insert = 1'b1;
			S_DONE: cmd.out_load = flg.out_free;
			default: ;
		endcase
	end

endmodule
`default_nettype wire

@@ hw/rtl/lottery_scheduler_table_top.sv @@
`default_nettype none
// Channel | Direction | Word
// req     | in        | action, thread_id, ticket_count, thread_running, random_value
// rsp     | out       | status, winner_id, winner_tickets, ticket_total, entry_count
//
// One request is handled at a time; req is ready only when the controller is idle.
// Remove walks the table until it finds the thread; add and yield walk it, then insert;
// a walk that finds nothing covers all entries. A non-running yield skips the walk.
// A draw first runs a bit-serial modulo of the random word by the ticket total.
// The response register lets the next request in while a response waits on rsp.ready.
// Reset clears the entry count and ticket total; table contents need no clearing.
module lottery_scheduler_table_top #(
	parameter int MAX_THREADS = lst_pkg::MaxThreadsDef
) (
	input wire logic  clk,
	input wire logic  arst_n,
	lst_req_if.sink   req,
	lst_rsp_if.source rsp
);
	import lst_pkg::*;

	cmd_t  cmd;
	flag_t flg;

	lst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.flg       (flg),
		.cmd       (cmd)
	);

	lst_dp #(
		.MAX_THREADS (MAX_THREADS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cmd    (cmd),
		.flg    (flg)
	);

endmodule
`default_nettype wire
